// ===== hw/rtl/u16550_pkg.sv =====
// ----------------------------------------------------------------------------
// u16550_pkg
// Shared types, register offsets, bit masks and reset values for the
// 16550-style UART register model.
// ----------------------------------------------------------------------------
package u16550_pkg;

    // Default receive FIFO depth.
    localparam int RX_FIFO_DEPTH_DEF = 1024;

    // Request kinds.
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_RX    = 2'd2,
        KIND_TICK  = 2'd3
    } t_kind;

    // Register offsets.
    localparam logic [7:0] OFF_DATA = 8'd0;   // RBR/THR or DLL
    localparam logic [7:0] OFF_IER  = 8'd1;   // IER or DLM
    localparam logic [7:0] OFF_IIR  = 8'd2;   // IIR/FCR or AFR
    localparam logic [7:0] OFF_LCR  = 8'd3;
    localparam logic [7:0] OFF_MCR  = 8'd4;
    localparam logic [7:0] OFF_LSR  = 8'd5;
    localparam logic [7:0] OFF_MSR  = 8'd6;
    localparam logic [7:0] OFF_SCR  = 8'd7;
    localparam logic [7:0] OFF_DSR  = 8'd16;

    // Bit masks and interrupt codes.
    localparam logic [7:0] LCR_DIV_LATCH     = 8'h80;
    localparam logic [7:0] IER_TX_EMPTY_EN   = 8'h02;
    localparam logic [7:0] IIR_NOINT         = 8'h01;
    localparam logic [7:0] IIR_THRE_CODE     = 8'h02;
    localparam logic [7:0] IIR_RDA_CODE      = 8'h04;
    localparam logic [7:0] IIR_ID_MASK       = 8'h0F;
    localparam logic [7:0] LSR_DR            = 8'h01;
    localparam logic [7:0] LSR_TX_HOLD_EMPTY = 8'h20;
    localparam logic [7:0] LSR_TX_IDLE       = 8'h40;
    localparam logic [7:0] FCR_ENABLE        = 8'h01;

    // Reset values.
    localparam logic [7:0] RST_DLL = 8'h01;
    localparam logic [7:0] RST_IIR = 8'h01;
    localparam logic [7:0] RST_LSR = 8'h60;
    localparam logic [7:0] RST_DSR = 8'h01;

    // Replaces the identification nibble of IIR with a new code.
    function automatic logic [7:0] set_ident(input logic [7:0] iir, input logic [7:0] code);
        set_ident = (iir & ~IIR_ID_MASK) | code;
    endfunction

endpackage

// ===== hw/rtl/u16550_ram.sv =====
// ----------------------------------------------------------------------------
// u16550_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module u16550_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hw/rtl/uart_16550_register_model_top.sv =====
// ----------------------------------------------------------------------------
// uart_16550_register_model_top
// Register side of a 16550-style UART: DLAB-banked register map, receive
// FIFO and one interrupt line. Bus reads, bus writes, received bytes and
// timer ticks each produce one result.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Payload
//  --------  -------------------  -------------------------------------------
//  request   i_valid / o_ready    i_kind, i_offset, i_wr_data, i_rx_byte
//  result    o_valid / i_ready    o_rd_data, o_access_error, o_tx_valid,
//                                 o_tx_byte, o_irq
//
// One request per cycle is sustained while results are taken. A request taken
// is held in the input stage and then moves into the result register. The
// FIFO RAM is read every cycle at the next head pointer, so the head byte is
// ready when a request reaches the processing stage. Reset is synchronous and
// empties the FIFO through its fill count. A stalled result holds both stages,
// and o_ready drops only while both are full and the result is not taken.
// ----------------------------------------------------------------------------
module uart_16550_register_model_top #(
    parameter int RX_FIFO_DEPTH = u16550_pkg::RX_FIFO_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  u16550_pkg::t_kind i_kind,
    input  logic [7:0]        i_offset,
    input  logic [7:0]        i_wr_data,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_rd_data,
    output logic              o_access_error,
    output logic              o_tx_valid,
    output logic [7:0]        o_tx_byte,
    output logic              o_irq
);

    import u16550_pkg::*;

    localparam int PTR_W = $clog2(RX_FIFO_DEPTH);
    localparam int CNT_W = $clog2(RX_FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RX_FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(RX_FIFO_DEPTH);

    // Input stage.
    logic        r_in_valid;
    t_kind       r_kind;
    logic [7:0]  r_offset;
    logic [7:0]  r_wr_data;
    logic [7:0]  r_rx_byte;

    // Result stage.
    logic        r_out_valid;
    logic [7:0]  r_rd_data;
    logic        r_access_error;
    logic        r_tx_valid;
    logic [7:0]  r_tx_byte;

    // Architectural registers.
    logic [7:0]  r_dll, n_dll;
    logic [7:0]  r_dlm, n_dlm;
    logic [7:0]  r_ier, n_ier;
    logic [7:0]  r_iir, n_iir;
    logic [7:0]  r_fcr, n_fcr;
    logic [7:0]  r_afr, n_afr;
    logic [7:0]  r_lcr, n_lcr;
    logic [7:0]  r_mcr, n_mcr;
    logic [7:0]  r_lsr, n_lsr;
    logic [7:0]  r_msr, n_msr;
    logic [7:0]  r_scr, n_scr;
    logic [7:0]  r_dsr, n_dsr;
    logic [PTR_W-1:0] r_head, n_head;
    logic [PTR_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic        r_irq, n_irq;

    // Read bypass for a push to the address being read in the same cycle.
    logic        r_byp_valid;
    logic [7:0]  r_byp_data;

    logic        advance;
    logic        dlab;
    logic        push;
    logic [7:0]  ram_q;
    logic [7:0]  head_data;
    logic [7:0]  res_rd_data;
    logic        res_access_error;
    logic        res_tx_valid;
    logic [7:0]  res_tx_byte;

    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign dlab    = (r_lcr & LCR_DIV_LATCH) != 8'h00;

    u16550_ram #(
        .WIDTH (8),
        .DEPTH (RX_FIFO_DEPTH)
    ) u_rx_ram (
        .i_clk     (i_clk),
        .i_wr_en   (push),
        .i_wr_addr (r_tail),
        .i_wr_data (r_rx_byte),
        .i_rd_addr (n_head),
        .o_rd_data (ram_q)
    );

    assign head_data = r_byp_valid ? r_byp_data : ram_q;

    always_comb begin
        n_dll = r_dll;
        n_dlm = r_dlm;
        n_ier = r_ier;
        n_iir = r_iir;
        n_fcr = r_fcr;
        n_afr = r_afr;
        n_lcr = r_lcr;
        n_mcr = r_mcr;
        n_lsr = r_lsr;
        n_msr = r_msr;
        n_scr = r_scr;
        n_dsr = r_dsr;
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_irq   = r_irq;
        push    = 1'b0;
        res_rd_data      = 8'h00;
        res_access_error = 1'b0;
        res_tx_valid     = 1'b0;
        res_tx_byte      = 8'h00;

        if (advance) begin
            unique case (r_kind)
                KIND_READ: begin
                    unique case (r_offset)
                        OFF_DATA: begin
                            if (dlab) begin
                                res_rd_data = r_dll;
                            end else begin
                                if (r_count != '0) begin
                                    res_rd_data = head_data;
                                    n_head  = (r_head == PTR_LAST) ? '0 : r_head + 1'b1;
                                    n_count = r_count - 1'b1;
                                end
                                if (n_count != '0) begin
                                    n_irq = 1'b1;
                                end else begin
                                    n_lsr = r_lsr & ~LSR_DR;
                                    n_iir = set_ident(r_iir, IIR_NOINT);
                                end
                            end
                        end
                        OFF_IER: res_rd_data = dlab ? r_dlm : r_ier;
                        OFF_IIR: begin
                            if (dlab) begin
                                res_rd_data = r_afr;
                            end else begin
                                res_rd_data = r_iir;
                                if ((r_iir & IIR_THRE_CODE) != 8'h00) begin
                                    n_iir = set_ident(r_iir, IIR_NOINT);
                                end
                            end
                        end
                        OFF_LCR: res_rd_data = r_lcr;
                        OFF_MCR: res_rd_data = r_mcr;
                        OFF_LSR: res_rd_data = r_lsr;
                        OFF_MSR: res_rd_data = r_msr;
                        OFF_SCR: res_rd_data = r_scr;
                        OFF_DSR: res_rd_data = r_dsr;
                        default: res_access_error = 1'b1;
                    endcase
                end
                KIND_WRITE: begin
                    unique case (r_offset)
                        OFF_DATA: begin
                            if (dlab) begin
                                n_dll = r_wr_data;
                            end else begin
                                res_tx_valid = 1'b1;
                                res_tx_byte  = r_wr_data;
                                n_lsr = r_lsr | LSR_TX_IDLE | LSR_TX_HOLD_EMPTY;
                            end
                        end
                        OFF_IER: begin
                            if (dlab) n_dlm = r_wr_data;
                            else      n_ier = r_wr_data;
                        end
                        OFF_IIR: begin
                            if (dlab) n_afr = r_wr_data;
                            else      n_fcr = r_wr_data;
                        end
                        OFF_LCR: n_lcr = r_wr_data;
                        OFF_MCR: n_mcr = r_wr_data;
                        OFF_LSR: n_lsr = r_wr_data;
                        OFF_MSR: n_msr = r_wr_data;
                        OFF_SCR: n_scr = r_wr_data;
                        OFF_DSR: n_dsr = r_wr_data;
                        default: res_access_error = 1'b1;
                    endcase
                end
                KIND_RX: begin
                    n_iir = set_ident(r_iir, IIR_RDA_CODE);
                    n_lsr = r_lsr | LSR_DR;
                    if ((r_fcr & FCR_ENABLE) != 8'h00) begin
                        // A full FIFO drops the byte but still raises the line.
                        if (r_count < CNT_FULL) begin
                            push    = 1'b1;
                            n_tail  = (r_tail == PTR_LAST) ? '0 : r_tail + 1'b1;
                            n_count = r_count + 1'b1;
                        end
                        n_irq = 1'b1;
                    end
                end
                KIND_TICK: begin
                    if ((r_lsr & LSR_TX_IDLE) != 8'h00) begin
                        if ((r_iir & IIR_NOINT) != 8'h00 &&
                            (r_ier & IER_TX_EMPTY_EN) != 8'h00) begin
                            n_iir = set_ident(r_iir, IIR_THRE_CODE);
                            n_lsr = r_lsr | LSR_TX_IDLE | LSR_TX_HOLD_EMPTY;
                        end
                        // The line follows the identification after any new post.
                        if ((n_iir & IIR_NOINT) == 8'h00) begin
                            n_irq = (r_ier & IER_TX_EMPTY_EN) != 8'h00;
                        end else begin
                            n_irq = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_byp_valid <= 1'b0;
            r_dll   <= RST_DLL;
            r_dlm   <= 8'h00;
            r_ier   <= 8'h00;
            r_iir   <= RST_IIR;
            r_fcr   <= 8'h00;
            r_afr   <= 8'h00;
            r_lcr   <= 8'h00;
            r_mcr   <= 8'h00;
            r_lsr   <= RST_LSR;
            r_msr   <= 8'h00;
            r_scr   <= 8'h00;
            r_dsr   <= RST_DSR;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_irq   <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            r_byp_valid <= push && (r_tail == n_head);
            r_dll   <= n_dll;
            r_dlm   <= n_dlm;
            r_ier   <= n_ier;
            r_iir   <= n_iir;
            r_fcr   <= n_fcr;
            r_afr   <= n_afr;
            r_lcr   <= n_lcr;
            r_mcr   <= n_mcr;
            r_lsr   <= n_lsr;
            r_msr   <= n_msr;
            r_scr   <= n_scr;
            r_dsr   <= n_dsr;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_irq   <= n_irq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_kind    <= i_kind;
            r_offset  <= i_offset;
            r_wr_data <= i_wr_data;
            r_rx_byte <= i_rx_byte;
        end
        if (advance) begin
            r_rd_data      <= res_rd_data;
            r_access_error <= res_access_error;
            r_tx_valid     <= res_tx_valid;
            r_tx_byte      <= res_tx_byte;
        end
        r_byp_data <= r_rx_byte;
    end

    // The line level shown is the one left by this result's request.
    logic r_irq_out;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_irq_out <= n_irq;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_rd_data      = r_rd_data;
    assign o_access_error = r_access_error;
    assign o_tx_valid     = r_tx_valid;
    assign o_tx_byte      = r_tx_byte;
    assign o_irq          = r_irq_out;

endmodule
